// ===== design/pcs_pkg.sv =====
// package for the phased chunk scheduler: types, codes and constants
`timescale 1ns / 1ps
package pcs_pkg;

  localparam int unsigned MaxGroupsDef = 256;
  localparam int unsigned IndexBits    = 24;
  localparam int unsigned PhaseBits    = 16;
  localparam int unsigned GroupReqBits = 9;
  localparam int unsigned HomeBits     = 8;
  localparam int unsigned AutoDivShift = 3;  // automatic size divides by groups*8
  localparam int unsigned DivBits      = IndexBits + 1;

  localparam logic [1:0] RegTotalItems = 2'd0;
  localparam logic [1:0] RegChunkSize  = 2'd1;
  localparam logic [1:0] RegGroupCount = 2'd2;
  localparam logic [1:0] RegPhaseCount = 2'd3;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_GRAB   = 2'd1,
    CMD_RETIRE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_GRANTED  = 2'd0,
    STAT_NONE     = 2'd1,
    STAT_FINISHED = 2'd2,
    STAT_ACK      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FILL,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    OP_AUTO,
    OP_BASE,
    OP_LIVE_HI,
    OP_LIVE_LO,
    OP_HOME
  } div_op_e;

  typedef struct packed {
    logic [1:0]           command;
    logic [HomeBits-1:0]  home_group;
    logic [IndexBits-1:0] retire_start;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [PhaseBits-1:0] phase;
    logic [IndexBits-1:0] chunk_start;
    logic [IndexBits-1:0] chunk_end;
  } res_t;

  typedef struct packed {
    logic [IndexBits-1:0] first;
    logic [IndexBits-1:0] stop;
    logic [PhaseBits-1:0] phase;
    logic [IndexBits-1:0] cursor;
    logic [IndexBits-1:0] live;
  } slice_t;

endpackage

// ===== design/phased_chunk_scheduler.sv =====
// phased chunk scheduler: group table, sequencer and shared serial divider
// start steps: up to 4 divisions, then one group table row written per group, then the emit step
// grab steps: a division for the home modulo (retire has none); then a read and a check per group scanned, then emit
// throughput: one request at a time, set by the serial divider and the scan of the group table
// a new request is taken while the previous response still waits in the output register
// reset: asynchronous active low; empty dispatch, chunk size one, group table left unwritten
`timescale 1ns / 1ps
module phased_chunk_scheduler #(
  parameter int unsigned MAX_GROUPS = pcs_pkg::MaxGroupsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pcs_pkg::req_t       in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pcs_pkg::res_t       out_res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import pcs_pkg::*;

  // widths that follow from the group table depth
  localparam int unsigned GW = $clog2(MAX_GROUPS + 1);
  localparam int unsigned AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned W  = DivBits;
  localparam int unsigned CW = $clog2(W);

  // configuration registers
  logic [IndexBits-1:0]    total_q, chunk_cfg_q;
  logic [GroupReqBits-1:0] gcount_q;
  logic [PhaseBits-1:0]    pcount_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      chunk_cfg_q <= '0;
      gcount_q    <= GroupReqBits'(1);
      pcount_q    <= PhaseBits'(1);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        RegTotalItems: total_q     <= pwdata[IndexBits-1:0];
        RegChunkSize:  chunk_cfg_q <= pwdata[IndexBits-1:0];
        RegGroupCount: gcount_q    <= pwdata[GroupReqBits-1:0];
        RegPhaseCount: pcount_q    <= pwdata[PhaseBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegTotalItems: prdata = 32'(total_q);
      RegChunkSize:  prdata = 32'(chunk_cfg_q);
      RegGroupCount: prdata = 32'(gcount_q);
      RegPhaseCount: prdata = 32'(pcount_q);
      default:       prdata = '0;
    endcase
  end

  // shared restoring divider, one quotient bit a cycle
  logic          div_go;
  logic [W-1:0]  div_a, div_b;
  logic [W-1:0]  dv_rem_q, dv_quo_q, dv_den_q;
  logic [CW-1:0] dv_cnt_q;
  logic          dv_busy_q;
  logic [W:0]    dv_sh;
  logic          dv_fit;

  assign dv_sh  = {dv_rem_q, dv_quo_q[W-1]};
  assign dv_fit = (dv_sh >= {1'b0, dv_den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_busy_q <= 1'b0;
      dv_cnt_q  <= '0;
      dv_rem_q  <= '0;
      dv_quo_q  <= '0;
      dv_den_q  <= '0;
    end else if (div_go) begin
      dv_busy_q <= 1'b1;
      dv_cnt_q  <= '0;
      dv_rem_q  <= '0;
      dv_quo_q  <= div_a;
      dv_den_q  <= div_b;
    end else if (dv_busy_q) begin
      dv_rem_q <= dv_fit ? W'(dv_sh - {1'b0, dv_den_q}) : dv_sh[W-1:0];
      dv_quo_q <= {dv_quo_q[W-2:0], dv_fit};
      dv_cnt_q <= dv_cnt_q + CW'(1);
      if (dv_cnt_q == CW'(W - 1)) begin
        dv_busy_q <= 1'b0;
      end
    end
  end

  // group table, one write and one registered read a cycle
  slice_t          mem_q [MAX_GROUPS];
  slice_t          rd_q;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  slice_t          mem_wd;

  // sequencer state
  state_e               state_q, state_d;
  div_op_e              op_q, op_d;
  logic [1:0]           cmd_q, cmd_d;
  logic [IndexBits-1:0] rs_q, rs_d;
  res_t                 res_q, res_d;
  logic [GW-1:0]        groups_q, groups_d;
  logic [GW-1:0]        fin_q, fin_d;
  logic [PhaseBits-1:0] phases_q, phases_d;
  logic [IndexBits-1:0] chunk_q, chunk_d;
  logic [IndexBits-1:0] base_q, base_d;
  logic [GW-1:0]        rem_q, rem_d;
  logic [IndexBits-1:0] live_hi_q, live_hi_d, live_lo_q, live_lo_d;
  logic [IndexBits-1:0] at_q, at_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [AW-1:0]        s_q, s_d;
  logic [GW-1:0]        k_q, k_d;
  logic                 out_valid_q;
  res_t                 out_q;
  logic                 out_load;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[s_q];
  end

  // clamped group count, worked out while the start request is taken
  logic [W-1:0] g_c;
  always_comb begin
    g_c = W'(gcount_q);
    if (g_c == '0) g_c = W'(1);
    if (g_c > W'(MAX_GROUPS)) g_c = W'(MAX_GROUPS);
    if (g_c > W'(total_q)) g_c = W'(total_q);
  end

  // datapath helpers for the fill and scan steps
  logic                 fill_long;
  logic [W-1:0]         fill_len;
  logic [W-1:0]         grab_hi;
  logic [IndexBits-1:0] live_dec;
  logic [PhaseBits-1:0] phase_inc;
  logic [GW-1:0]        k_inc;
  logic [AW-1:0]        s_next;

  assign fill_long = (GW'(idx_q) < rem_q);
  assign fill_len  = W'(base_q) + W'(fill_long);
  assign grab_hi   = (W'(rd_q.cursor) + W'(chunk_q) > W'(rd_q.stop)) ? W'(rd_q.stop)
                   : W'(rd_q.cursor) + W'(chunk_q);
  assign live_dec  = rd_q.live - IndexBits'(1);
  assign phase_inc = rd_q.phase + PhaseBits'(1);
  assign k_inc     = k_q + GW'(1);
  assign s_next    = (GW'(s_q) + GW'(1) == groups_q) ? '0 : s_q + AW'(1);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    cmd_d     = cmd_q;
    rs_d      = rs_q;
    res_d     = res_q;
    groups_d  = groups_q;
    fin_d     = fin_q;
    phases_d  = phases_q;
    chunk_d   = chunk_q;
    base_d    = base_q;
    rem_d     = rem_q;
    live_hi_d = live_hi_q;
    live_lo_d = live_lo_q;
    at_d      = at_q;
    idx_d     = idx_q;
    s_d       = s_q;
    k_d       = k_q;
    div_go    = 1'b0;
    div_a     = '0;
    div_b     = W'(1);
    mem_we    = 1'b0;
    mem_wa    = s_q;
    mem_wd    = rd_q;
    out_load  = 1'b0;
    in_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d = in_req_i.command;
          rs_d  = in_req_i.retire_start;
          res_d = '{status: STAT_ACK, default: '0};
          state_d = ST_EMIT;
          unique case (in_req_i.command)
            CMD_START: begin
              fin_d = '0;
              if (total_q == '0 || pcount_q == '0) begin
                groups_d = '0;
              end else begin
                groups_d = GW'(g_c);
                phases_d = pcount_q;
                div_a    = W'(total_q);
                state_d  = ST_DIV;
                div_go   = 1'b1;
                if (chunk_cfg_q == '0) begin
                  div_b = W'(g_c << AutoDivShift);
                  op_d  = OP_AUTO;
                end else begin
                  chunk_d = chunk_cfg_q;
                  div_b   = g_c;
                  op_d    = OP_BASE;
                end
              end
            end
            CMD_GRAB: begin
              if (fin_q == groups_q) begin
                res_d.status = STAT_FINISHED;
              end else begin
                div_go  = 1'b1;
                div_a   = W'(in_req_i.home_group);
                div_b   = W'(groups_q);
                op_d    = OP_HOME;
                state_d = ST_DIV;
              end
            end
            CMD_RETIRE: begin
              if (groups_q != '0) begin
                s_d     = '0;
                k_d     = '0;
                state_d = ST_SCAN_RD;
              end
            end
            default: ;
          endcase
        end
      end

      ST_DIV: begin
        if (!dv_busy_q && !div_go) begin
          unique case (op_q)
            OP_AUTO: begin
              chunk_d = IndexBits'(dv_quo_q) + IndexBits'(1);
              div_go  = 1'b1;
              div_a   = W'(total_q);
              div_b   = W'(groups_q);
              op_d    = OP_BASE;
            end
            OP_BASE: begin
              base_d = IndexBits'(dv_quo_q);
              rem_d  = GW'(dv_rem_q);
              div_go = 1'b1;
              div_a  = dv_quo_q + W'(chunk_q);
              div_b  = W'(chunk_q);
              op_d   = OP_LIVE_HI;
            end
            OP_LIVE_HI: begin
              live_hi_d = IndexBits'(dv_quo_q);
              div_go    = 1'b1;
              div_a     = W'(base_q) + W'(chunk_q) - W'(1);
              div_b     = W'(chunk_q);
              op_d      = OP_LIVE_LO;
            end
            OP_LIVE_LO: begin
              live_lo_d = IndexBits'(dv_quo_q);
              idx_d     = '0;
              at_d      = '0;
              state_d   = ST_FILL;
            end
            OP_HOME: begin
              s_d     = AW'(dv_rem_q);
              k_d     = '0;
              state_d = ST_SCAN_RD;
            end
            default: ;
          endcase
        end
      end

      ST_FILL: begin
        mem_we        = 1'b1;
        mem_wa        = idx_q;
        mem_wd.first  = at_q;
        mem_wd.stop   = IndexBits'(W'(at_q) + fill_len);
        mem_wd.phase  = '0;
        mem_wd.cursor = at_q;
        mem_wd.live   = fill_long ? live_hi_q : live_lo_q;
        at_d          = IndexBits'(W'(at_q) + fill_len);
        idx_d         = idx_q + AW'(1);
        if (GW'(idx_q) + GW'(1) == groups_q) begin
          state_d = ST_EMIT;
        end
      end

      ST_SCAN_RD: begin
        state_d = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        state_d = ST_SCAN_RD;
        s_d     = s_next;
        k_d     = k_inc;
        if (k_inc == groups_q) begin
          state_d = ST_EMIT;
          if (cmd_q == CMD_GRAB) res_d.status = STAT_NONE;
        end
        if (cmd_q == CMD_GRAB) begin
          if (rd_q.phase < phases_q && rd_q.cursor < rd_q.stop) begin
            mem_we        = 1'b1;
            mem_wd.cursor = IndexBits'(grab_hi);
            res_d.status      = STAT_GRANTED;
            res_d.phase       = rd_q.phase;
            res_d.chunk_start = rd_q.cursor;
            res_d.chunk_end   = IndexBits'(grab_hi);
            state_d = ST_EMIT;
          end
        end else if (rs_q >= rd_q.first && rs_q < rd_q.stop) begin
          state_d = ST_EMIT;
          if (rd_q.phase < phases_q && rd_q.live != '0) begin
            mem_we      = 1'b1;
            mem_wd.live = live_dec;
            if (live_dec == '0) begin
              mem_wd.phase = phase_inc;
              if (phase_inc >= phases_q) begin
                fin_d = fin_q + GW'(1);
              end else begin
                mem_wd.cursor = rd_q.first;
                mem_wd.live   = (rd_q.stop - rd_q.first == base_q) ? live_lo_q : live_hi_q;
              end
            end
          end
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_AUTO;
      cmd_q     <= '0;
      rs_q      <= '0;
      res_q     <= '0;
      groups_q  <= '0;
      fin_q     <= '0;
      phases_q  <= '0;
      chunk_q   <= IndexBits'(1);
      base_q    <= '0;
      rem_q     <= '0;
      live_hi_q <= '0;
      live_lo_q <= '0;
      at_q      <= '0;
      idx_q     <= '0;
      s_q       <= '0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      cmd_q     <= cmd_d;
      rs_q      <= rs_d;
      res_q     <= res_d;
      groups_q  <= groups_d;
      fin_q     <= fin_d;
      phases_q  <= phases_d;
      chunk_q   <= chunk_d;
      base_q    <= base_d;
      rem_q     <= rem_d;
      live_hi_q <= live_hi_d;
      live_lo_q <= live_lo_d;
      at_q      <= at_d;
      idx_q     <= idx_d;
      s_q       <= s_d;
      k_q       <= k_d;
    end
  end

  // output register parts the sequencer from the consumer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
      out_q       <= res_q;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // finished groups never outnumber the groups in use
  a_fin_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q <= groups_q) else $error("finished count above group count");

  // chunk size stays nonzero so the divider never sees a zero divisor
  a_chunk_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chunk_q != '0) else $error("chunk size is zero");

  // a taken request keeps the block busy in the next cycle
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("request taken while busy");

  // the fill pass writes only rows below the group count
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FILL |-> GW'(idx_q) < groups_q) else $error("fill beyond group count");

endmodule
